/* design/m3h_pkg.sv */
// Shared constants, types and state codes for the MurmurHash3 x86_32 stream hasher.
`timescale 1ns / 1ps
package m3h_pkg;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [2:0] NB_FULL = 3'd4;

  // Mixed key on its way from the front to the back
  typedef struct packed {
    logic [31:0] key;
    logic [2:0]  nb;
    logic        last;
  } m3h_item_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_FIN1,
    BK_FIN2,
    BK_FIN3
  } m3h_state_e;

endpackage

/* design/m3h_front.sv */
// Front end: accept words, clamp and mask bytes, key mix in two multiply stages.
`timescale 1ns / 1ps
module m3h_front
  import m3h_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        is_last_i,
  output logic        push_o,
  output m3h_item_t   push_item_o,
  input  logic        push_ready_i
);

  logic        en;
  logic [2:0]  nb_sat;
  logic [31:0] masked;
  logic [31:0] s2_rot;

  logic        s1_valid_q, s2_valid_q;
  logic [31:0] s1_key_q, s2_key_q;
  logic [2:0]  s1_nb_q, s2_nb_q;
  logic        s1_last_q, s2_last_q;

  // Stall the whole pipe only when the tail item cannot leave
  assign en         = !(s2_valid_q && !push_ready_i);
  assign in_ready_o = en;

  always_comb begin
    nb_sat = (valid_bytes_i > NB_FULL) ? NB_FULL : valid_bytes_i;
    unique case (nb_sat)
      3'd0:    masked = 32'h0000_0000;
      3'd1:    masked = {24'h0, data_word_i[7:0]};
      3'd2:    masked = {16'h0, data_word_i[15:0]};
      3'd3:    masked = {8'h0, data_word_i[23:0]};
      default: masked = data_word_i;
    endcase
  end

  assign s2_rot = {s1_key_q[16:0], s1_key_q[31:17]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_key_q  <= masked * MIX_C1;
      s1_nb_q   <= nb_sat;
      s1_last_q <= is_last_i;
      s2_key_q  <= s2_rot * MIX_C2;
      s2_nb_q   <= s1_nb_q;
      s2_last_q <= s1_last_q;
    end
  end

  assign push_o           = s2_valid_q;
  assign push_item_o.key  = s2_key_q;
  assign push_item_o.nb   = s2_nb_q;
  assign push_item_o.last = s2_last_q;

endmodule

/* design/m3h_queue.sv */
// Short first-in first-out queue between the front and the back.
`timescale 1ns / 1ps
module m3h_queue
  import m3h_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  m3h_item_t push_item_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output m3h_item_t pop_item_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  m3h_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

/* design/m3h_back.sv */
// Back end: running hash update, length count, fmix32 sequencer and result register.
`timescale 1ns / 1ps
module m3h_back
  import m3h_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  m3h_item_t              item_i,
  output logic                   pop_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [OUT_TDATA_W-1:0] m_data_o
);

  m3h_state_e  state_q, state_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] len_q, len_d;
  logic [31:0] work_q, work_d;
  logic [31:0] out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] h_xor, h_rot, h_upd, len_upd;
  logic        out_free;

  assign out_free = !out_valid_q || m_ready_i;

  // Block mix for full words, plain xor for a tail, no change for an empty word
  always_comb begin
    h_xor   = hash_q ^ item_i.key;
    h_rot   = {h_xor[18:0], h_xor[31:19]};
    len_upd = len_q + {29'h0, item_i.nb};
    if (item_i.nb == NB_FULL) begin
      h_upd = (h_rot << 2) + h_rot + MIX_ADD;
    end else if (item_i.nb != 3'd0) begin
      h_upd = h_xor;
    end else begin
      h_upd = hash_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_RUN:  if (item_valid_i && item_i.last) state_d = BK_FIN1;
      BK_FIN1: state_d = BK_FIN2;
      BK_FIN2: state_d = BK_FIN3;
      BK_FIN3: if (out_free) state_d = BK_RUN;
      default: state_d = BK_RUN;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    hash_d      = hash_q;
    len_d       = len_q;
    work_d      = work_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_ready_i;
    unique case (state_q)
      BK_RUN: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if (item_i.last) begin
            work_d = h_upd ^ len_upd;
            hash_d = '0;
            len_d  = '0;
          end else begin
            hash_d = h_upd;
            len_d  = len_upd;
          end
        end
      end
      BK_FIN1: work_d = (work_q ^ (work_q >> 16)) * FIN_M1;
      BK_FIN2: work_d = (work_q ^ (work_q >> 13)) * FIN_M2;
      BK_FIN3: begin
        if (out_free) begin
          out_d       = work_q ^ (work_q >> 16);
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      hash_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    out_q  <= out_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

endmodule

/* design/murmur3_32_hash_stream_top.sv */
// Top level of the MurmurHash3 x86_32 (seed 0) stream hasher.
`timescale 1ns / 1ps
//
//  Channel  Direction  Payload                                   Transfer when
//  s_axis   in         tdata: data_word[31:0], valid_bytes[34:32] tvalid & tready
//                      tlast: is_last
//  m_axis   out        tdata: hash_value[31:0]                    tvalid & tready
//
//  A word passes the front key-mix multiply stages, is written into the
//  queue, then updates the running hash in the back; one word per cycle
//  streams through while no message ends. A last word holds the back in the
//  fmix32 states BK_FIN1, BK_FIN2 and BK_FIN3 (two registered multiplies and
//  the final xor-shift); BK_FIN3 waits until the result register is free.
//  Reset clears the pipe valids, the queue, the hash, the length and the
//  result valid flag. A stalled result stalls only the back; the queue keeps
//  the front accepting until it fills.
module murmur3_32_hash_stream_top
  import m3h_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // data_word[31:0], valid_bytes[34:32], zero pad
  input  logic                   s_axis_tlast_i,  // is_last
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // hash_value[31:0]
);

  logic      push, push_ready;
  m3h_item_t push_item;
  logic      pop, pop_valid;
  m3h_item_t pop_item;

  // Classify and key-mix each incoming transfer
  m3h_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .data_word_i   (s_axis_tdata_i[31:0]),
    .valid_bytes_i (s_axis_tdata_i[34:32]),
    .is_last_i     (s_axis_tlast_i),
    .push_o        (push),
    .push_item_o   (push_item),
    .push_ready_i  (push_ready)
  );

  // Decouple the front from the finaliser
  m3h_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  // Fold keys into the hash and finalise on the last transfer
  m3h_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (m_axis_tdata_o)
  );

endmodule

/* tb/m3h_hash_check.sv */
// Stream monitor for the hasher: predicts each message hash and compares it with the result.
`timescale 1ns / 1ps
module m3h_hash_check
  import m3h_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,   // data_word[31:0], valid_bytes[34:32], zero pad
  input  logic                   s_tlast_i,   // is_last
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,   // hash_value[31:0]
  output int unsigned            fail_count_o,
  output int unsigned            hashes_due_o,
  output int unsigned            hashes_seen_o
);

  // Running state of the message in flight, as seen from the input side
  logic [31:0] msg_hash;
  logic [31:0] msg_len;
  logic [31:0] hash_due_q[$];

  // Key mix: multiply, rotate left 15, multiply
  function automatic logic [31:0] scramble_key(input logic [31:0] k);
    logic [31:0] t;
    t = k * MIX_C1;
    t = {t[16:0], t[31:17]};
    return t * MIX_C2;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [31:0] word;
    logic [31:0] h;
    logic [31:0] fin;
    logic [2:0]  nb;
    if (!rst_ni) begin
      msg_hash      <= '0;
      msg_len       <= '0;
      hash_due_q.delete();
      fail_count_o  <= 0;
      hashes_due_o  <= 0;
      hashes_seen_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (hash_due_q.size() == 0) begin
          $error("hash_value: result %h arrived with no hash expected", m_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          fin = hash_due_q.pop_front();
          if (m_tdata_i !== fin) begin
            $error("hash_value mismatch: expected %h, got %h", fin, m_tdata_i);
            fail_count_o <= fail_count_o + 1;
          end
          hashes_seen_o <= hashes_seen_o + 1;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        word = s_tdata_i[31:0];
        nb   = s_tdata_i[34:32];
        // byte counts above a full word clamp to a full word
        if (nb > NB_FULL) nb = NB_FULL;
        h = msg_hash;
        if (nb == NB_FULL) begin
          h ^= scramble_key(word);
          h = {h[18:0], h[31:19]};
          h = h * 5 + MIX_ADD;
        end else if (nb != 0) begin
          // tail mix on the valid low bytes only
          h ^= scramble_key(word & ~(32'hffffffff << (8 * nb)));
        end
        if (s_tlast_i) begin
          fin = h ^ (msg_len + nb);
          fin ^= fin >> 16;
          fin = fin * FIN_M1;
          fin ^= fin >> 13;
          fin = fin * FIN_M2;
          fin ^= fin >> 16;
          hash_due_q.push_back(fin);
          msg_hash <= '0;
          msg_len  <= '0;
        end else begin
          msg_hash <= h;
          msg_len  <= msg_len + nb;
        end
      end
      hashes_due_o <= hash_due_q.size();
    end
  end

endmodule

/* tb/murmur3_32_hash_stream_top_test.sv */
// Stimulus and verdict for the MurmurHash3 x86_32 stream hasher testbench.
`timescale 1ns / 1ps
module murmur3_32_hash_stream_top_test;
  import m3h_pkg::*;

  // Stop feeding once this many words have gone in
  localparam int unsigned WORD_TARGET    = 650;
  // Long output hold-off that backs the pipe up into the input
  localparam int unsigned SQUEEZE_CYCLES = 300;
  // Back-to-back one-word messages offered while the output is held
  localparam int unsigned SQUEEZE_MSGS   = 48;
  // Settle time after the last hash: front, queue and fmix stages
  localparam int unsigned DRAIN_CYCLES   = 16;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // data_word[31:0], valid_bytes[34:32], zero pad
  logic                   s_axis_tlast_i;   // is_last
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // hash_value[31:0]

  int unsigned fail_count;
  int unsigned hashes_due;
  int unsigned hashes_seen;
  int unsigned words_sent    = 0;
  int unsigned messages_sent = 0;

  // Sender runs without gaps while set
  bit steady       = 1'b0;
  // Handshake between the stimulus and the output hold-off
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;

  murmur3_32_hash_stream_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  m3h_hash_check u_hash_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid_i),
    .s_tready_i    (s_axis_tready_o),
    .s_tdata_i     (s_axis_tdata_i),
    .s_tlast_i     (s_axis_tlast_i),
    .m_tvalid_i    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .m_tdata_i     (m_axis_tdata_o),
    .fail_count_o  (fail_count),
    .hashes_due_o  (hashes_due),
    .hashes_seen_o (hashes_seen)
  );

  always #4 clk_i = ~clk_i;

  // Idle length: mostly none, often short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Idle first (so valid is never dropped and raised in one step), then
  // offer the word and hold it until the transfer happens.
  task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic last);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'({nbytes, word});
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_sent++;
    if (last) messages_sent++;
  endtask

  // Hard stop in case the block hangs; well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: ready in bursts, dropped for random gaps, and once held
  // low for a long stretch on request so the block fills and stalls its input.
  initial begin : sink
    int unsigned hold;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      m_axis_tready_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12))
        @(posedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        hold         = SQUEEZE_CYCLES;
        squeeze_done = 1'b1;
      end else begin
        hold = pick_gap();
      end
      if (hold != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [2:0]  nb;
    int unsigned len;
    int unsigned pick;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message: zero bytes, hash must come out as zero
    send_word(32'h00000000, 3'd0, 1'b1);
    // One-, two- and three-byte messages with junk above the valid bytes
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'h12345678, 3'd2, 1'b1);
    send_word(32'hdeadbeef, 3'd3, 1'b1);
    // Single full words at both extremes
    send_word(32'h00000000, NB_FULL, 1'b1);
    send_word(32'hffffffff, NB_FULL, 1'b1);
    // Byte counts beyond a full word clamp to four
    send_word(32'hcafef00d, 3'd5, 1'b1);
    send_word(32'h0badc0de, 3'd6, 1'b0);
    send_word(32'h13579bdf, 3'd7, 1'b1);
    // Two full words ending in a three-byte tail
    send_word(32'h01234567, NB_FULL, 1'b0);
    send_word(32'h89abcdef, NB_FULL, 1'b0);
    send_word(32'hfedcba98, 3'd3, 1'b1);
    // Partial word in mid-message, then an empty last word
    send_word(32'hffffffff, 3'd2, 1'b0);
    send_word(32'h76543210, NB_FULL, 1'b0);
    send_word(32'h00000000, 3'd0, 1'b1);
    // Zero-byte word that is not last
    send_word(32'hffffffff, 3'd0, 1'b0);
    send_word(32'haaaaaaaa, 3'd1, 1'b1);
    // Full word then an empty closing word
    send_word(32'h80000001, NB_FULL, 1'b0);
    send_word(32'h7ffffffe, 3'd0, 1'b1);

    // Random messages: mostly well-formed full words with a tail of any
    // size, some with stray byte counts mid-message.
    while (words_sent < WORD_TARGET) begin
      if (!squeeze_req && words_sent >= 250) begin
        // Hold the output off and keep offering short messages back to back
        squeeze_req = 1'b1;
        steady      = 1'b1;
        repeat (SQUEEZE_MSGS) send_word($urandom, 3'($urandom_range(0, 4)), 1'b1);
      end
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      len    = (pick < 70) ? $urandom_range(1, 6) :
               (pick < 90) ? $urandom_range(7, 20) : $urandom_range(1, 2);
      for (int i = 1; i <= len; i++) begin
        if (i < len)
          nb = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : NB_FULL;
        else
          nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        send_word($urandom, nb, i == len);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    // Let the checker's count take in the final transfer before reading it
    @(posedge clk_i);

    // Drain: wait for every predicted hash, then let the settle time pass for strays
    while (hashes_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d words in %0d messages, %0d hashes compared.",
             words_sent, messages_sent, hashes_seen);
    $display("Covered empty, masked-tail and clamped byte counts and a %0d-cycle output stall.",
             SQUEEZE_CYCLES);
    if (fail_count == 0 && hashes_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/m3h_pkg.sv
design/m3h_front.sv
design/m3h_queue.sv
design/m3h_back.sv
design/murmur3_32_hash_stream_top.sv
tb/m3h_hash_check.sv
tb/murmur3_32_hash_stream_top_test.sv
